// ===== hdl/chip8_instruction_core_macros.svh =====
// Assertion macros for the CHIP-8 core top file.
// Needs nothing else; take it in by include with the bare file name.
`ifndef CHIP8_INSTRUCTION_CORE_MACROS_SVH
`define CHIP8_INSTRUCTION_CORE_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define CHP8_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chp8 assertion failed");
// Next-cycle implication, disabled during reset.
`define CHP8_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chp8 assertion failed");
`endif

// ===== hdl/chp8_pkg.sv =====
// Shared types and constants for the CHIP-8 instruction core.
// No dependencies; the control, datapath and top files import it.
package chp8_pkg;

   localparam int ADDR_W    = 12;
   localparam int MEM_DEPTH = 4096;
   localparam int SCREEN_W  = 64;
   localparam int SCREEN_H  = 32;
   localparam int ROW_W     = 5;
   localparam int NUM_REGS  = 16;
   localparam int COL_W     = 6;

   localparam logic [3:0]        REG_VF      = 4'hF;
   localparam logic [ADDR_W-1:0] FONT_RESET  = 12'd80;
   localparam logic [ADDR_W-1:0] START_RESET = 12'd512;

   localparam logic CSR_FONT_BASE = 1'b0;
   localparam logic CSR_START     = 1'b1;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_EXEC  = 2'd1,
      FUNC_ROW   = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [19:0] {
      ST_IDLE     = 20'h00001,
      ST_MEM_WR   = 20'h00002,
      ST_ROW_RD   = 20'h00004,
      ST_ROW_CAP  = 20'h00008,
      ST_FETCH_HI = 20'h00010,
      ST_FETCH_LO = 20'h00020,
      ST_READ_X   = 20'h00040,
      ST_READ_Y   = 20'h00080,
      ST_OPER     = 20'h00100,
      ST_EXEC     = 20'h00200,
      ST_RET      = 20'h00400,
      ST_WR_VF    = 20'h00800,
      ST_DRAW_RD  = 20'h01000,
      ST_DRAW_WR  = 20'h02000,
      ST_BCD_WR   = 20'h04000,
      ST_SAVE_RD  = 20'h08000,
      ST_SAVE_WR  = 20'h10000,
      ST_LOAD_RD  = 20'h20000,
      ST_LOAD_WR  = 20'h40000,
      ST_DONE     = 20'h80000
   } state_type;

   typedef enum logic [2:0] {
      K_NONE = 3'd0,
      K_RET  = 3'd1,
      K_FLAG = 3'd2,
      K_DRAW = 3'd3,
      K_BCD  = 3'd4,
      K_SAVE = 3'd5,
      K_LOAD = 3'd6
   } kind_type;

   typedef struct packed {
      state_type state;
      logic      accept;
   } cmd_type;

   typedef struct packed {
      func_type func;
      kind_type kind;
      logic     last;
      logic     out_free;
   } status_type;

endpackage

// ===== hdl/chp8_if.sv =====
// Channel interfaces of the CHIP-8 core: request, response and register write.
// Depends on nothing.
interface chp8_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [11:0] mem_address;
   logic [7:0]  write_byte;
   logic [4:0]  row_select;
   logic [15:0] keys_down;
   logic [7:0]  random_byte;
   modport source (output valid, func, mem_address, write_byte, row_select, keys_down,
                   random_byte, input ready);
   modport sink (input valid, func, mem_address, write_byte, row_select, keys_down,
                 random_byte, output ready);
endinterface

interface chp8_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] pc_out;
   logic [15:0] index_out;
   logic [7:0]  flag_out;
   logic [15:0] opcode;
   logic        undefined_op;
   logic        key_wait;
   logic        sound_on;
   logic [63:0] row_bits;
   modport source (output valid, pc_out, index_out, flag_out, opcode, undefined_op,
                   key_wait, sound_on, row_bits, input ready);
   modport sink (input valid, pc_out, index_out, flag_out, opcode, undefined_op,
                 key_wait, sound_on, row_bits, output ready);
endinterface

interface chp8_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [11:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/chp8_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module chp8_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      rdata_ff <= store_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hdl/chp8_ctrl.sv =====
// Sequencer of the CHIP-8 core: one-hot state machine stepping each item.
// Depends on chp8_pkg.
module chp8_ctrl import chp8_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;

   assign req_ready  = (state_ff == ST_IDLE);
   assign cmd.state  = state_ff;
   assign cmd.accept = req_ready && req_valid;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (status.func)
                  FUNC_WRITE: state_in = ST_MEM_WR;
                  FUNC_EXEC:  state_in = ST_FETCH_HI;
                  FUNC_ROW:   state_in = ST_ROW_RD;
                  FUNC_NONE:  state_in = ST_DONE;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_MEM_WR:   state_in = ST_DONE;
         ST_ROW_RD:   state_in = ST_ROW_CAP;
         ST_ROW_CAP:  state_in = ST_DONE;
         ST_FETCH_HI: state_in = ST_FETCH_LO;
         ST_FETCH_LO: state_in = ST_READ_X;
         ST_READ_X:   state_in = ST_READ_Y;
         ST_READ_Y:   state_in = ST_OPER;
         ST_OPER:     state_in = ST_EXEC;
         ST_EXEC: begin
            unique case (status.kind)
               K_RET:   state_in = ST_RET;
               K_FLAG:  state_in = ST_WR_VF;
               K_DRAW:  state_in = ST_DRAW_RD;
               K_BCD:   state_in = ST_BCD_WR;
               K_SAVE:  state_in = ST_SAVE_RD;
               K_LOAD:  state_in = ST_LOAD_RD;
               default: state_in = ST_DONE;
            endcase
         end
         ST_RET:      state_in = ST_DONE;
         ST_WR_VF:    state_in = ST_DONE;
         ST_DRAW_RD:  state_in = ST_DRAW_WR;
         ST_DRAW_WR:  state_in = status.last ? ST_WR_VF : ST_DRAW_RD;
         ST_BCD_WR:   state_in = status.last ? ST_DONE : ST_BCD_WR;
         ST_SAVE_RD:  state_in = ST_SAVE_WR;
         ST_SAVE_WR:  state_in = status.last ? ST_DONE : ST_SAVE_RD;
         ST_LOAD_RD:  state_in = ST_LOAD_WR;
         ST_LOAD_WR:  state_in = status.last ? ST_DONE : ST_LOAD_RD;
         // hold until the output register can take the result
         ST_DONE:     state_in = status.out_free ? ST_IDLE : ST_DONE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== hdl/chp8_dpath.sv =====
// Datapath of the CHIP-8 core: architectural registers, memories, output register.
// Depends on chp8_pkg and chp8_ram.
module chp8_dpath import chp8_pkg::*; #(
   parameter int STACK_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [1:0]  req_func,
   input  logic [11:0] req_mem_address,
   input  logic [7:0]  req_write_byte,
   input  logic [4:0]  req_row_select,
   input  logic [15:0] req_keys_down,
   input  logic [7:0]  req_random_byte,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [11:0] csr_data,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [11:0] rsp_pc_out,
   output logic [15:0] rsp_index_out,
   output logic [7:0]  rsp_flag_out,
   output logic [15:0] rsp_opcode,
   output logic        rsp_undefined_op,
   output logic        rsp_key_wait,
   output logic        rsp_sound_on,
   output logic [63:0] rsp_row_bits
);
   localparam int SP_W = $clog2(STACK_DEPTH);

   // architectural state
   logic [ADDR_W-1:0] pc_ff, pc_in;
   logic [15:0]       idx_ff, idx_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic [7:0]        delay_ff, delay_in;
   logic [7:0]        sound_ff, sound_in;
   logic [7:0]        vf_ff;
   logic [ADDR_W-1:0] font_ff;
   logic [NUM_REGS-1:0] reg_valid_ff;
   logic [SCREEN_H-1:0] fb_valid_ff;
   logic              reg_rv_ff, fb_rv_ff;

   // per-item registers
   func_type          func_ff;
   logic [11:0]       addr_ff;
   logic [7:0]        wbyte_ff;
   logic [4:0]        rowsel_ff;
   logic [15:0]       keys_ff;
   logic [7:0]        rnd_ff;
   logic [7:0]        hi_ff;
   logic [15:0]       op_ff, op_in;
   logic [7:0]        vx_ff, vx_in, vy_ff, vy_in;
   logic [3:0]        i_ff, i_in;
   logic              hit_ff, hit_in;
   logic [7:0]        flag_ff, flag_in;
   logic              undef_ff, undef_in;
   logic              wait_ff, wait_in;
   logic [63:0]       row_ff, row_in;

   // output register
   logic        rsp_valid_ff, rsp_load;
   logic [11:0] rsp_pc_ff;
   logic [15:0] rsp_idx_ff, rsp_op_ff;
   logic [7:0]  rsp_flag_ff;
   logic        rsp_undef_ff, rsp_wait_ff, rsp_sound_ff;
   logic [63:0] rsp_row_ff;

   // memory ports
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata, mem_q;
   logic              reg_we;
   logic [3:0]        reg_waddr, reg_raddr;
   logic [7:0]        reg_wdata, reg_q, reg_q_eff;
   logic              fb_we, fb_clear;
   logic [ROW_W-1:0]  fb_waddr, fb_raddr;
   logic [63:0]       fb_wdata, fb_q, fb_q_eff;
   logic              stk_we;
   logic [SP_W-1:0]   sp_plus, sp_minus;
   logic [11:0]       stk_q;

   // decode and helpers
   logic [3:0]  op_x, op_y, op_n;
   logic [7:0]  op_nn;
   logic [11:0] op_nnn;
   kind_type    kind;
   logic        last;
   logic [8:0]  sum9;
   logic [15:0] isum;
   logic [8:0]  draw_row;
   logic        draw_ok;
   logic [63:0] sprite_mask;
   logic        key_down;
   logic [3:0]  first_key;
   logic [1:0]  bcd_h;
   logic [7:0]  bcd_r;
   logic [14:0] bcd_prod;
   logic [3:0]  bcd_t;
   logic [7:0]  bcd_o;
   logic [7:0]  bcd_digit;
   logic [ADDR_W-1:0] idx_off;

   assign op_x   = op_ff[11:8];
   assign op_y   = op_ff[7:4];
   assign op_n   = op_ff[3:0];
   assign op_nn  = op_ff[7:0];
   assign op_nnn = op_ff[11:0];

   assign sp_plus  = (sp_ff == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_ff + 1'b1;
   assign sp_minus = (sp_ff == '0) ? SP_W'(STACK_DEPTH - 1) : sp_ff - 1'b1;

   assign reg_q_eff = reg_rv_ff ? reg_q : 8'd0;
   assign fb_q_eff  = fb_rv_ff ? fb_q : 64'd0;
   assign idx_off   = idx_ff[ADDR_W-1:0] + {8'd0, i_ff};

   assign sum9     = {1'b0, vx_ff} + {1'b0, vy_ff};
   assign isum     = idx_ff + {8'd0, vx_ff};
   assign draw_row = {1'b0, vy_ff} + {5'd0, i_ff};
   assign draw_ok  = (draw_row < 9'(SCREEN_H)) && (vx_ff < 8'(SCREEN_W));
   assign sprite_mask = {mem_q, 56'd0} >> vx_ff[COL_W-1:0];
   assign key_down = (vx_ff[7:4] == 4'd0) && keys_ff[vx_ff[3:0]];

   always_comb begin
      first_key = 4'd0;
      for (int k = NUM_REGS - 1; k >= 0; k--) begin
         if (keys_ff[k]) begin
            first_key = 4'(k);
         end
      end
   end

   // decimal digits: hundreds by compare, tens by reciprocal multiply
   always_comb begin
      if (vx_ff >= 8'd200) begin
         bcd_h = 2'd2;
         bcd_r = vx_ff - 8'd200;
      end else if (vx_ff >= 8'd100) begin
         bcd_h = 2'd1;
         bcd_r = vx_ff - 8'd100;
      end else begin
         bcd_h = 2'd0;
         bcd_r = vx_ff;
      end
      bcd_prod = {8'd0, bcd_r[6:0]} * 15'd205;
      bcd_t    = bcd_prod[14:11];
      bcd_o    = bcd_r - {4'd0, bcd_t} * 8'd10;
      priority case (i_ff)
         4'd0:    bcd_digit = {6'd0, bcd_h};
         4'd1:    bcd_digit = {4'd0, bcd_t};
         default: bcd_digit = bcd_o;
      endcase
   end

   always_comb begin
      pc_in     = pc_ff;
      idx_in    = idx_ff;
      sp_in     = sp_ff;
      delay_in  = delay_ff;
      sound_in  = sound_ff;
      op_in     = op_ff;
      vx_in     = vx_ff;
      vy_in     = vy_ff;
      i_in      = i_ff;
      hit_in    = hit_ff;
      flag_in   = flag_ff;
      undef_in  = undef_ff;
      wait_in   = wait_ff;
      row_in    = row_ff;
      kind      = K_NONE;
      last      = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = idx_off;
      mem_wdata = reg_q_eff;
      mem_raddr = idx_off;
      reg_we    = 1'b0;
      reg_waddr = op_x;
      reg_wdata = 8'd0;
      reg_raddr = op_x;
      fb_we     = 1'b0;
      fb_clear  = 1'b0;
      fb_waddr  = draw_row[ROW_W-1:0];
      fb_wdata  = fb_q_eff ^ sprite_mask;
      fb_raddr  = draw_row[ROW_W-1:0];
      stk_we    = 1'b0;
      if (cmd.accept) begin
         undef_in = 1'b0;
         wait_in  = 1'b0;
      end
      unique case (cmd.state)
         ST_MEM_WR: begin
            mem_we    = 1'b1;
            mem_waddr = addr_ff;
            mem_wdata = wbyte_ff;
         end
         ST_ROW_RD:   fb_raddr = rowsel_ff;
         ST_ROW_CAP:  row_in = fb_q_eff;
         ST_FETCH_HI: mem_raddr = pc_ff;
         ST_FETCH_LO: mem_raddr = pc_ff + 12'd2 - 12'd1;
         ST_READ_X: begin
            op_in     = {hi_ff, mem_q};
            reg_raddr = hi_ff[3:0];
            pc_in     = pc_ff + 12'd2;
         end
         ST_READ_Y: begin
            vx_in     = reg_q_eff;
            // jump with offset reads V0 in place of Vy
            reg_raddr = (op_ff[15:12] == 4'hB) ? 4'd0 : op_y;
         end
         ST_OPER: vy_in = reg_q_eff;
         ST_EXEC: begin
            i_in   = 4'd0;
            hit_in = 1'b0;
            unique case (op_ff[15:12])
               4'h0: begin
                  if (op_nn == 8'hE0) begin
                     fb_clear = 1'b1;
                  end else if (op_nn == 8'hEE) begin
                     sp_in = sp_minus;
                     kind  = K_RET;
                  end else begin
                     undef_in = 1'b1;
                  end
               end
               4'h1: pc_in = op_nnn;
               4'h2: begin
                  stk_we = 1'b1;
                  sp_in  = sp_plus;
                  pc_in  = op_nnn;
               end
               4'h3: if (vx_ff == op_nn) pc_in = pc_ff + 12'd2;
               4'h4: if (vx_ff != op_nn) pc_in = pc_ff + 12'd2;
               4'h5: begin
                  if (op_n != 4'd0) undef_in = 1'b1;
                  else if (vx_ff == vy_ff) pc_in = pc_ff + 12'd2;
               end
               4'h6: begin
                  reg_we    = 1'b1;
                  reg_wdata = op_nn;
               end
               4'h7: begin
                  reg_we    = 1'b1;
                  reg_wdata = vx_ff + op_nn;
               end
               4'h8: begin
                  reg_we = 1'b1;
                  unique case (op_n)
                     4'h0: reg_wdata = vy_ff;
                     4'h1: reg_wdata = vx_ff | vy_ff;
                     4'h2: reg_wdata = vx_ff & vy_ff;
                     4'h3: reg_wdata = vx_ff ^ vy_ff;
                     4'h4: begin
                        reg_wdata = sum9[7:0];
                        flag_in   = {7'd0, sum9[8]};
                        kind      = K_FLAG;
                     end
                     4'h5: begin
                        reg_wdata = vx_ff - vy_ff;
                        flag_in   = {7'd0, vx_ff >= vy_ff};
                        kind      = K_FLAG;
                     end
                     4'h7: begin
                        reg_wdata = vy_ff - vx_ff;
                        flag_in   = {7'd0, vy_ff >= vx_ff};
                        kind      = K_FLAG;
                     end
                     4'h6: begin
                        reg_wdata = {1'b0, vx_ff[7:1]};
                        flag_in   = {7'd0, vx_ff[0]};
                        kind      = K_FLAG;
                     end
                     4'hE: begin
                        reg_wdata = {vx_ff[6:0], 1'b0};
                        flag_in   = {7'd0, vx_ff[7]};
                        kind      = K_FLAG;
                     end
                     default: begin
                        reg_we   = 1'b0;
                        undef_in = 1'b1;
                     end
                  endcase
               end
               4'h9: begin
                  if (op_n != 4'd0) undef_in = 1'b1;
                  else if (vx_ff != vy_ff) pc_in = pc_ff + 12'd2;
               end
               4'hA: idx_in = {4'd0, op_nnn};
               4'hB: pc_in = op_nnn + {4'd0, vy_ff};
               4'hC: begin
                  reg_we    = 1'b1;
                  reg_wdata = rnd_ff & op_nn;
               end
               4'hD: begin
                  // an empty sprite only clears the flag
                  flag_in = 8'd0;
                  kind    = (op_n == 4'd0) ? K_FLAG : K_DRAW;
               end
               4'hE: begin
                  if (op_nn == 8'h9E) begin
                     if (key_down) pc_in = pc_ff + 12'd2;
                  end else if (op_nn == 8'hA1) begin
                     if (!key_down) pc_in = pc_ff + 12'd2;
                  end else begin
                     undef_in = 1'b1;
                  end
               end
               4'hF: begin
                  unique case (op_nn)
                     8'h07: begin
                        reg_we    = 1'b1;
                        reg_wdata = delay_ff;
                     end
                     8'h0A: begin
                        if (keys_ff != 16'd0) begin
                           reg_we    = 1'b1;
                           reg_wdata = {4'd0, first_key};
                        end else begin
                           pc_in   = pc_ff - 12'd2;
                           wait_in = 1'b1;
                        end
                     end
                     8'h15: delay_in = vx_ff;
                     8'h18: sound_in = vx_ff;
                     8'h1E: begin
                        idx_in  = isum;
                        flag_in = {7'd0, isum[15:12] != 4'd0};
                        kind    = K_FLAG;
                     end
                     8'h29: idx_in = {4'd0, font_ff} + 16'({vx_ff[3:0], 2'b00})
                                     + {12'd0, vx_ff[3:0]};
                     8'h33: kind = K_BCD;
                     8'h55: kind = K_SAVE;
                     8'h65: kind = K_LOAD;
                     default: undef_in = 1'b1;
                  endcase
               end
               default: undef_in = 1'b1;
            endcase
         end
         ST_RET: pc_in = stk_q;
         ST_WR_VF: begin
            reg_we    = 1'b1;
            reg_waddr = REG_VF;
            reg_wdata = flag_ff;
         end
         ST_DRAW_RD: ;
         ST_DRAW_WR: begin
            fb_we = draw_ok;
            if (draw_ok && ((fb_q_eff & sprite_mask) != 64'd0)) begin
               hit_in = 1'b1;
            end
            last    = (i_ff == op_n - 4'd1);
            flag_in = {7'd0, hit_in};
            i_in    = i_ff + 4'd1;
         end
         ST_BCD_WR: begin
            mem_we    = 1'b1;
            mem_wdata = bcd_digit;
            last      = (i_ff == 4'd2);
            i_in      = i_ff + 4'd1;
         end
         ST_SAVE_RD: reg_raddr = i_ff;
         ST_SAVE_WR: begin
            mem_we = 1'b1;
            last   = (i_ff == op_x);
            i_in   = i_ff + 4'd1;
         end
         ST_LOAD_RD: ;
         ST_LOAD_WR: begin
            reg_we    = 1'b1;
            reg_waddr = i_ff;
            reg_wdata = mem_q;
            last      = (i_ff == op_x);
            i_in      = i_ff + 4'd1;
         end
         ST_IDLE, ST_DONE: ;
         default: ;
      endcase
   end

   assign rsp_load = (cmd.state == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign status.func     = func_type'(req_func);
   assign status.kind     = kind;
   assign status.last     = last;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= START_RESET;
         idx_ff       <= 16'd0;
         sp_ff        <= '0;
         delay_ff     <= 8'd0;
         sound_ff     <= 8'd0;
         vf_ff        <= 8'd0;
         font_ff      <= FONT_RESET;
         reg_valid_ff <= '0;
         fb_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff    <= pc_in;
         idx_ff   <= idx_in;
         sp_ff    <= sp_in;
         delay_ff <= delay_in;
         sound_ff <= sound_in;
         if (reg_we) begin
            reg_valid_ff[reg_waddr] <= 1'b1;
            if (reg_waddr == REG_VF) vf_ff <= reg_wdata;
         end
         if (fb_clear) begin
            fb_valid_ff <= '0;
         end else if (fb_we) begin
            fb_valid_ff[fb_waddr] <= 1'b1;
         end
         // the start address only matters at reset, where it is back at 512
         if (csr_we) begin
            unique case (csr_index)
               CSR_FONT_BASE: font_ff <= csr_data;
               CSR_START:     ;
               default:       ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff   <= func_type'(req_func);
         addr_ff   <= req_mem_address;
         wbyte_ff  <= req_write_byte;
         rowsel_ff <= req_row_select;
         keys_ff   <= req_keys_down;
         rnd_ff    <= req_random_byte;
      end
      if (cmd.state == ST_FETCH_LO) hi_ff <= mem_q;
      reg_rv_ff <= reg_valid_ff[reg_raddr];
      fb_rv_ff  <= fb_valid_ff[fb_raddr];
      op_ff     <= op_in;
      vx_ff     <= vx_in;
      vy_ff     <= vy_in;
      i_ff      <= i_in;
      hit_ff    <= hit_in;
      flag_ff   <= flag_in;
      undef_ff  <= undef_in;
      wait_ff   <= wait_in;
      row_ff    <= row_in;
      if (rsp_load) begin
         rsp_pc_ff    <= pc_ff;
         rsp_idx_ff   <= idx_ff;
         rsp_flag_ff  <= vf_ff;
         rsp_op_ff    <= (func_ff == FUNC_EXEC) ? op_ff : 16'd0;
         rsp_undef_ff <= (func_ff == FUNC_EXEC) && undef_ff;
         rsp_wait_ff  <= (func_ff == FUNC_EXEC) && wait_ff;
         rsp_sound_ff <= (sound_ff != 8'd0);
         rsp_row_ff   <= (func_ff == FUNC_ROW) ? row_ff : 64'd0;
      end
   end

   chp8_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_main_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_q)
   );

   chp8_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_data_regs (
      .clock (clock),
      .we    (reg_we),
      .waddr (reg_waddr),
      .wdata (reg_wdata),
      .raddr (reg_raddr),
      .rdata (reg_q)
   );

   chp8_ram #(.WIDTH(SCREEN_W), .DEPTH(SCREEN_H)) u_frame_buf (
      .clock (clock),
      .we    (fb_we),
      .waddr (fb_waddr),
      .wdata (fb_wdata),
      .raddr (fb_raddr),
      .rdata (fb_q)
   );

   chp8_ram #(.WIDTH(ADDR_W), .DEPTH(STACK_DEPTH)) u_ret_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (sp_ff),
      .wdata (pc_ff),
      .raddr (sp_minus),
      .rdata (stk_q)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pc_out       = rsp_pc_ff;
   assign rsp_index_out    = rsp_idx_ff;
   assign rsp_flag_out     = rsp_flag_ff;
   assign rsp_opcode       = rsp_op_ff;
   assign rsp_undefined_op = rsp_undef_ff;
   assign rsp_key_wait     = rsp_wait_ff;
   assign rsp_sound_on     = rsp_sound_ff;
   assign rsp_row_bits     = rsp_row_ff;
endmodule

// ===== hdl/chip8_instruction_core.sv =====
// CHIP-8 instruction core. Main memory and the register file have one read port each, so
// each item steps through the sequencer states: a draw reads and then writes each sprite
// row, and a save or load reads and then writes each register; BCD writes its digits in
// turn, hundreds first. The result sits in an output register while the next item
// is accepted. Synchronous reset clears PC to 512, I, SP, timers, registers and
// the screen; main memory and the return stack hold garbage until written.
module chip8_instruction_core import chp8_pkg::*; #(
   parameter int STACK_DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   chp8_req_if.sink   req_bus,
   chp8_rsp_if.source rsp_bus,
   chp8_csr_if.sink   csr_bus
);
`include "chip8_instruction_core_macros.svh"

   cmd_type    cmd;
   status_type status;

   assign csr_bus.ready = 1'b1;

   chp8_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   chp8_dpath #(.STACK_DEPTH(STACK_DEPTH)) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req_bus.func),
      .req_mem_address  (req_bus.mem_address),
      .req_write_byte   (req_bus.write_byte),
      .req_row_select   (req_bus.row_select),
      .req_keys_down    (req_bus.keys_down),
      .req_random_byte  (req_bus.random_byte),
      .csr_we           (csr_bus.valid),
      .csr_index        (csr_bus.index),
      .csr_data         (csr_bus.data),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_pc_out       (rsp_bus.pc_out),
      .rsp_index_out    (rsp_bus.index_out),
      .rsp_flag_out     (rsp_bus.flag_out),
      .rsp_opcode       (rsp_bus.opcode),
      .rsp_undefined_op (rsp_bus.undefined_op),
      .rsp_key_wait     (rsp_bus.key_wait),
      .rsp_sound_on     (rsp_bus.sound_on),
      .rsp_row_bits     (rsp_bus.row_bits)
   );

   // one item in flight: no new beat right after an accepted one
   `CHP8_ASSERT_NEXT(a_one_item, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready)
   // a finished item always lands in the output register
   `CHP8_ASSERT_NEXT(a_done_loads, clock, reset, (cmd.state == ST_DONE) && status.out_free, rsp_bus.valid)
   // the sequencer only takes a beat when idle
   `CHP8_ASSERT_NOW(a_accept_idle, clock, reset, cmd.accept, req_bus.ready && (cmd.state == ST_IDLE))
endmodule
